>>> sv/cdjd_pkg.sv
// Shared types, constants and tables of the calendar date to day number block.
// Used by cdjd_pipe and calendar_date_to_julian_day_top; depends on nothing.
package cdjd_pkg;

    localparam int YEAR_W = 21;
    localparam int DATE_W = 35;
    localparam int DN_W   = 30;
    localparam int SEC_W  = 17;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 56;

    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 21'sd1000000;
    localparam logic signed [YEAR_W-1:0] YEAR_MIN = -21'sd1000000;

    localparam logic signed [DATE_W-1:0] LAST_OLD_RESET  = 35'sd17520902;
    localparam logic signed [DATE_W-1:0] FIRST_NEW_RESET = 35'sd17520914;

    // Reciprocal of 100 scaled by 2**27, exact for magnitudes below 2**20.
    localparam logic [20:0] RECIP_100 = 21'd1342178;
    localparam int          RECIP_SH  = 27;

    localparam logic signed [DN_W-1:0] MJD_OFFSET   = 30'sd679004;
    localparam logic signed [DN_W-1:0] JULIAN_BIAS  = 30'sd1181;
    localparam logic signed [21:0]     JULIAN_SHIFT = 22'sd4716;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_YEAR   = 3'd1,
        ST_DAY    = 3'd2,
        ST_HOUR   = 3'd3,
        ST_MINUTE = 3'd4,
        ST_SECOND = 3'd5,
        ST_MONTH  = 3'd6,
        ST_GAP    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_LAST_OLD  = 2'd0,
        CFG_FIRST_NEW = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATE_W-1:0] last_old;
        logic signed [DATE_W-1:0] first_new;
    } t_cfg;

    // floor(30.6001 * (m + 1)) for the shifted months 3 to 14.
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] v;
        begin
            case (m)
                4'd3:    v = 9'd122;
                4'd4:    v = 9'd153;
                4'd5:    v = 9'd183;
                4'd6:    v = 9'd214;
                4'd7:    v = 9'd244;
                4'd8:    v = 9'd275;
                4'd9:    v = 9'd306;
                4'd10:   v = 9'd336;
                4'd11:   v = 9'd367;
                4'd12:   v = 9'd397;
                4'd13:   v = 9'd428;
                4'd14:   v = 9'd459;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> sv/cdjd_pipe.sv
// Three-stage datapath: range checks, calendar switch compare, leap offset and sum.
// Depends on cdjd_pkg.
module cdjd_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [cdjd_pkg::YEAR_W-1:0] i_year,
    input  logic [3:0]                     i_month,
    input  logic [5:0]                     i_day,
    input  logic [4:0]                     i_hour,
    input  logic [5:0]                     i_minute,
    input  logic [5:0]                     i_second,
    input  cdjd_pkg::t_cfg                 i_cfg,
    output logic                           o_valid,
    output cdjd_pkg::t_status              o_status,
    output logic signed [cdjd_pkg::DN_W-1:0] o_day_number,
    output logic [cdjd_pkg::SEC_W-1:0]     o_seconds
);
    import cdjd_pkg::*;

    // Stage 1 registers.
    logic                      r1_v;
    t_status                   r1_st;
    logic signed [DATE_W-1:0]  r1_date;
    logic signed [YEAR_W-1:0]  r1_y;
    logic [8:0]                r1_mdays;
    logic [5:0]                r1_day;
    logic [SEC_W-1:0]          r1_secs;

    // Stage 2 registers.
    logic                      r2_v;
    t_status                   r2_st;
    logic                      r2_julian;
    logic                      r2_yneg;
    logic [17:0]               r2_q4;
    logic [13:0]               r2_q100;
    logic signed [DN_W-1:0]    r2_bj;
    logic signed [DN_W-1:0]    r2_y365;
    logic [8:0]                r2_mdays;
    logic [5:0]                r2_day;
    logic [SEC_W-1:0]          r2_secs;

    // Stage 3 (output) registers.
    logic                      r3_v;
    t_status                   r3_st;
    logic signed [DN_W-1:0]    r3_dn;
    logic [SEC_W-1:0]          r3_secs;

    // Stage 1 logic.
    t_status                   w_st1;
    logic [10:0]               w_md;
    logic signed [DATE_W-1:0]  w_year_x;
    logic signed [DATE_W-1:0]  w_date;
    logic                      w_early;
    logic signed [YEAR_W-1:0]  w_y;
    logic [3:0]                w_m;
    logic [SEC_W-1:0]          w_secs;

    always_comb begin
        if (i_year < YEAR_MIN || i_year > YEAR_MAX) begin
            w_st1 = ST_YEAR;
        end else if (i_day < 6'd1 || i_day > 6'd31) begin
            w_st1 = ST_DAY;
        end else if (i_hour > 5'd23) begin
            w_st1 = ST_HOUR;
        end else if (i_minute > 6'd59) begin
            w_st1 = ST_MINUTE;
        end else if (i_second > 6'd59) begin
            w_st1 = ST_SECOND;
        end else if (i_month < 4'd1 || i_month > 4'd12) begin
            w_st1 = ST_MONTH;
        end else begin
            w_st1 = ST_OK;
        end
        w_md     = 11'(i_month * 7'd100) + {5'd0, i_day};
        w_year_x = DATE_W'(i_year);
        w_date   = w_year_x * 35'sd10000 + $signed({24'd0, w_md});
        w_early  = (i_month <= 4'd2);
        w_y      = w_early ? i_year - 21'sd1 : i_year;
        w_m      = w_early ? i_month + 4'd12 : i_month;
        w_secs   = 17'(i_hour * 12'd3600) + 17'(i_minute * 6'd60) + {11'd0, i_second};
    end

    // Stage 2 logic.
    logic                      w_gap;
    logic                      w_yneg;
    logic [19:0]               w_ya;
    logic signed [21:0]        w_yj;
    logic [19:0]               w_yja;
    logic [40:0]               w_prod;
    logic signed [DN_W-1:0]    w_q4j;

    always_comb begin
        w_gap  = (r1_date > i_cfg.last_old) && (r1_date < i_cfg.first_new);
        w_yneg = r1_y[YEAR_W-1];
        w_ya   = w_yneg ? 20'(-r1_y) : 20'(r1_y);
        w_yj   = 22'(r1_y) + JULIAN_SHIFT;
        w_yja  = w_yj[21] ? 20'(-w_yj) : 20'(w_yj);
        w_prod = 41'(w_ya) * 41'(RECIP_100);
        w_q4j  = $signed({12'd0, w_yja[19:2]});
    end

    // Stage 3 logic.
    logic [18:0]               w_mag;
    logic signed [DN_W-1:0]    w_bg;
    logic signed [DN_W-1:0]    w_b;
    logic signed [DN_W-1:0]    w_dn;

    always_comb begin
        w_mag = {1'b0, r2_q4} - {5'd0, r2_q100} + {7'd0, r2_q100[13:2]};
        w_bg  = r2_yneg ? -$signed({11'd0, w_mag}) : $signed({11'd0, w_mag});
        w_b   = r2_julian ? r2_bj : w_bg;
        w_dn  = r2_y365 - MJD_OFFSET + w_b + $signed({21'd0, r2_mdays})
              + $signed({24'd0, r2_day});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_st    <= w_st1;
            r1_date  <= w_date;
            r1_y     <= w_y;
            r1_mdays <= month_days(w_m);
            r1_day   <= i_day;
            r1_secs  <= w_secs;

            r2_st     <= (r1_st == ST_OK && w_gap) ? ST_GAP : r1_st;
            r2_julian <= (r1_date <= i_cfg.last_old);
            r2_yneg   <= w_yneg;
            r2_q4     <= w_ya[19:2];
            r2_q100   <= w_prod[RECIP_SH+13:RECIP_SH];
            r2_bj     <= (w_yj[21] ? -w_q4j : w_q4j) - JULIAN_BIAS;
            r2_y365   <= DN_W'(r1_y) * 30'sd365;
            r2_mdays  <= r1_mdays;
            r2_day    <= r1_day;
            r2_secs   <= r1_secs;

            r3_st   <= r2_st;
            r3_dn   <= (r2_st == ST_OK) ? w_dn : '0;
            r3_secs <= (r2_st == ST_OK) ? r2_secs : '0;
        end
    end

    assign o_valid      = r3_v;
    assign o_status     = r3_st;
    assign o_day_number = r3_dn;
    assign o_seconds    = r3_secs;

endmodule

>>> sv/calendar_date_to_julian_day_top.sv
// Top level of the calendar date to day number converter: stream ports,
// configuration registers and output packing. Depends on cdjd_pkg and cdjd_pipe.
//
// A date and time word enters on the s_axis channel and one result word leaves
// on the m_axis channel for every word taken in, in the same order. The Julian
// date of a result is day_number + 2400000.5 + seconds_of_day / 86400; any
// nonzero status comes with zero day number and zero seconds.
// A word accepted on s_axis passes in order through the stage 1, stage 2 and
// stage 3 registers, and the stage 3 valid bit drives m_axis_tvalid. The
// pipeline takes one word per cycle while the receiver keeps m_axis_tready high.
// The three stages advance together: while the output word is held waiting for
// m_axis_tready, s_axis_tready is low and every stage keeps its contents, so
// nothing is dropped or repeated. Empty stages are filled while the output
// register is empty.
// Reset clears all stage valid bits and loads the calendar switch registers
// with 1752-09-02 as the last Julian date and 1752-09-14 as the first
// Gregorian date. The switch registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no word is in
// flight, which the block does not enforce; unused indexes are ignored.
module calendar_date_to_julian_day_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year_in[20:0], month_in[24:21], day_in[30:25], hour_in[35:31],
    // minute_in[41:36], second_in[47:42]
    input  logic [cdjd_pkg::IN_W-1:0]   s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], day_number[32:3], seconds_of_day[49:33], zero fill [55:50]
    output logic [cdjd_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [cdjd_pkg::DATE_W-1:0] i_cfg_data
);
    import cdjd_pkg::*;

    t_cfg                    r_cfg;
    t_cfg                    n_cfg;
    logic                    w_adv;
    logic                    w_out_v;
    t_status                 w_status;
    logic signed [DN_W-1:0]  w_dn;
    logic [SEC_W-1:0]        w_secs;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAST_OLD:  n_cfg.last_old  = $signed(i_cfg_data);
                CFG_FIRST_NEW: n_cfg.first_new = $signed(i_cfg_data);
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.last_old  <= LAST_OLD_RESET;
            r_cfg.first_new <= FIRST_NEW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_adv         = !w_out_v || m_axis_tready;
    assign s_axis_tready = w_adv;

    cdjd_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_valid      (s_axis_tvalid),
        .i_year       ($signed(s_axis_tdata[20:0])),
        .i_month      (s_axis_tdata[24:21]),
        .i_day        (s_axis_tdata[30:25]),
        .i_hour       (s_axis_tdata[35:31]),
        .i_minute     (s_axis_tdata[41:36]),
        .i_second     (s_axis_tdata[47:42]),
        .i_cfg        (r_cfg),
        .o_valid      (w_out_v),
        .o_status     (w_status),
        .o_day_number (w_dn),
        .o_seconds    (w_secs)
    );

    assign m_axis_tvalid = w_out_v;
    assign m_axis_tdata  = {6'd0, w_secs, w_dn, w_status};

endmodule

>>> dv/calendar_date_to_julian_day_checker.sv
`timescale 1ns / 100ps
// Scoreboard for calendar_date_to_julian_day_top. It tracks the calendar switch
// registers, predicts status, day number and seconds for each date word taken in,
// and compares them with the result words. Depends on cdjd_pkg.
module calendar_date_to_julian_day_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [cdjd_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [cdjd_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [cdjd_pkg::DATE_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import cdjd_pkg::*;

    typedef struct packed {
        t_status                status;
        logic signed [DN_W-1:0] day_number;
        logic [SEC_W-1:0]       seconds;
    } t_day_result;

    t_day_result              day_results_q[$];
    logic signed [DATE_W-1:0] last_old_date;
    logic signed [DATE_W-1:0] first_new_date;
    int                       fail_total = 0;

    function automatic t_day_result convert_date(input logic [IN_W-1:0] w,
                                                 input logic signed [DATE_W-1:0] last_old,
                                                 input logic signed [DATE_W-1:0] first_new);
        t_day_result r;
        longint      yr, mo, dy, hr, mi, sc, stamp, cal_corr, dn;
        yr = longint'($signed(w[20:0]));
        mo = longint'(w[24:21]);
        dy = longint'(w[30:25]);
        hr = longint'(w[35:31]);
        mi = longint'(w[41:36]);
        sc = longint'(w[47:42]);
        cal_corr = 0;
        r = '{status: ST_OK, day_number: '0, seconds: '0};
        if (yr < -1000000 || yr > 1000000) begin
            r.status = ST_YEAR;
        end else if (dy < 1 || dy > 31) begin
            r.status = ST_DAY;
        end else if (hr > 23) begin
            r.status = ST_HOUR;
        end else if (mi > 59) begin
            r.status = ST_MINUTE;
        end else if (sc > 59) begin
            r.status = ST_SECOND;
        end else if (mo < 1 || mo > 12) begin
            r.status = ST_MONTH;
        end else begin
            // The switch comparison uses the date before the January and February shift.
            stamp = 10000 * yr + 100 * mo + dy;
            if (mo <= 2) begin
                mo += 12;
                yr -= 1;
            end
            if (stamp <= longint'(last_old)) begin
                cal_corr = -2 + (yr + 4716) / 4 - 1179;
            end else if (stamp >= longint'(first_new)) begin
                cal_corr = yr / 400 - yr / 100 + yr / 4;
            end else begin
                r.status = ST_GAP;
            end
            if (r.status == ST_OK) begin
                dn = 365 * yr - 679004 + cal_corr + (306001 * (mo + 1)) / 10000 + dy;
                r.day_number = dn[DN_W-1:0];
                r.seconds    = SEC_W'(hr * 3600 + mi * 60 + sc);
            end
        end
        return r;
    endfunction

    task automatic log_failure(input string what);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_day_result want, got;
        if (!i_rst_n) begin
            last_old_date  <= LAST_OLD_RESET;
            first_new_date <= FIRST_NEW_RESET;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status     = t_status'(m_axis_tdata[2:0]);
                got.day_number = m_axis_tdata[DN_W+2:3];
                got.seconds    = m_axis_tdata[SEC_W+DN_W+2:DN_W+3];
                if (day_results_q.size() == 0) begin
                    log_failure($sformatf("result word with nothing expected: st %0d dn %0d s %0d",
                                          got.status, got.day_number, got.seconds));
                end else begin
                    want = day_results_q.pop_front();
                    if (want.status != got.status || want.day_number != got.day_number ||
                        want.seconds != got.seconds) begin
                        log_failure($sformatf({"mismatch: expected st %0d dn %0d s %0d,",
                                               " got st %0d dn %0d s %0d"},
                                              want.status, want.day_number, want.seconds,
                                              got.status, got.day_number, got.seconds));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                day_results_q.push_back(convert_date(s_axis_tdata, last_old_date,
                                                     first_new_date));
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LAST_OLD:  last_old_date  <= i_cfg_data;
                    CFG_FIRST_NEW: first_new_date <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= day_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> dv/calendar_date_to_julian_day_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for calendar_date_to_julian_day_top: clock, reset, date word stimulus,
// switch register writes and the verdict. Depends on cdjd_pkg, the block and
// calendar_date_to_julian_day_checker.
module calendar_date_to_julian_day_top_tb;
    import cdjd_pkg::*;

    localparam int         LATENCY          = 3;
    localparam int         LONG_HOLD        = 300;
    localparam int         IDLE_LIMIT       = 4000;
    localparam int         RANDOM_PER_PHASE = 250;
    localparam int         NUM_PHASES       = 8;
    localparam int         RANDOM_PHASE     = 5;
    localparam int         PRESSURE_PHASE   = 5;
    localparam int         SPARE_PHASE      = 4;
    localparam logic [1:0] CFG_SPARE_A      = 2'd2;
    localparam logic [1:0] CFG_SPARE_B      = 2'd3;
    localparam longint     DATE_LOW         = -64'sd10000000000;
    localparam longint     DATE_HIGH        = 64'sd10000001231;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [DATE_W-1:0] i_cfg_data;

    int     fail_count;
    int     pending;
    logic   hold_flip;
    int     burst_left;
    bit     gapless;
    longint switch_date;

    calendar_date_to_julian_day_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    calendar_date_to_julian_day_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [IN_W-1:0] pack_date(input int y, input int mo, input int d,
                                                  input int h, input int mi, input int s);
        return {s[5:0], mi[5:0], h[4:0], d[5:0], mo[3:0], y[20:0]};
    endfunction

    function automatic logic [IN_W-1:0] random_date();
        int          kind, y, mo, d, h, mi, s, sw_month;
        logic [63:0] raw;
        kind = $urandom_range(0, 99);
        y    = int'($urandom_range(0, 2000000)) - 1000000;
        mo   = $urandom_range(1, 12);
        d    = $urandom_range(1, 31);
        h    = $urandom_range(0, 23);
        mi   = $urandom_range(0, 59);
        s    = $urandom_range(0, 59);
        sw_month = int'((switch_date / 100) % 100);
        if (kind < 15) begin
            y = int'(switch_date / 10000);
            if (sw_month >= 1 && sw_month <= 12) begin
                mo = sw_month;
            end
        end else if (kind < 25) begin
            y = int'(switch_date / 10000) + int'($urandom_range(0, 2)) - 1;
        end else if (kind < 40) begin
            y = int'($urandom_range(0, 8000)) - 6000;
        end else if (kind < 45) begin
            case ($urandom_range(0, 3))
                0:       y = 1000000;
                1:       y = -1000000;
                2:       y = 1000001;
                default: y = -1000001;
            endcase
        end else if (kind < 55) begin
            mo = $urandom_range(0, 15);
            d  = $urandom_range(0, 63);
            h  = $urandom_range(0, 31);
            mi = $urandom_range(0, 63);
            s  = $urandom_range(0, 63);
        end else if (kind < 62) begin
            raw = {$urandom, $urandom};
            return raw[IN_W-1:0];
        end
        return pack_date(y, mo, d, h, mi, s);
    endfunction

    task automatic send_item(input logic [IN_W-1:0] w);
        int gap;
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(10, 30);
                default:    gap = $urandom_range(1, 4);
            endcase
            if (gapless) begin
                gap = 0;
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_switch(input logic [1:0] idx, input longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[DATE_W-1:0];
        @(posedge i_clk);
    endtask

    // Receiver: changes its stall pattern now and then, and holds off for a long
    // stretch whenever the stimulus toggles hold_flip.
    initial begin
        logic hold_seen;
        int   stall_mode, mode_left;
        m_axis_tready = 1'b0;
        hold_seen     = 1'b0;
        mode_left     = 0;
        stall_mode    = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 4);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                3:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ((mode_left % 3) != 0);
            endcase
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) === 1'b1 ||
                (m_axis_tvalid && m_axis_tready) === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("calendar_date_to_julian_day_top_tb NOT OK");
        $finish;
    end

    initial begin
        longint last_tab[NUM_PHASES];
        longint first_tab[NUM_PHASES];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        hold_flip     = 1'b0;
        burst_left    = 0;
        gapless       = 1'b0;
        switch_date   = 17520902;
        last_tab  = '{17520902, 15821004, DATE_LOW, DATE_HIGH, 20000101, 0, DATE_LOW,
                      17520902};
        first_tab = '{17520914, 15821015, DATE_LOW, DATE_HIGH, 19000101, 0, DATE_HIGH,
                      17520914};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, each status in check order, the switch gap and the month shift.
        send_item(pack_date(1000000, 12, 31, 23, 59, 59));
        send_item(pack_date(-1000000, 1, 1, 0, 0, 0));
        send_item(pack_date(1000001, 6, 15, 12, 0, 0));
        send_item(pack_date(-1000001, 6, 15, 12, 0, 0));
        send_item(pack_date(-1048576, 0, 0, 31, 63, 63));
        send_item(pack_date(1048575, 15, 63, 31, 63, 63));
        send_item(pack_date(2000, 6, 0, 12, 30, 30));
        send_item(pack_date(2000, 6, 32, 12, 30, 30));
        send_item(pack_date(2000, 0, 63, 31, 63, 63));
        send_item(pack_date(2000, 15, 10, 24, 0, 0));
        send_item(pack_date(2000, 6, 10, 31, 0, 0));
        send_item(pack_date(2000, 0, 10, 12, 60, 0));
        send_item(pack_date(2000, 6, 10, 12, 63, 60));
        send_item(pack_date(2000, 0, 10, 12, 0, 60));
        send_item(pack_date(2000, 6, 10, 12, 0, 63));
        send_item(pack_date(2000, 0, 10, 12, 0, 0));
        send_item(pack_date(2000, 13, 10, 12, 0, 0));
        send_item(pack_date(1752, 9, 3, 6, 0, 0));
        send_item(pack_date(1752, 9, 13, 6, 0, 0));
        send_item(pack_date(1752, 9, 2, 23, 59, 59));
        send_item(pack_date(1752, 9, 14, 0, 0, 0));
        send_item(pack_date(2000, 1, 1, 0, 0, 0));
        send_item(pack_date(2000, 2, 29, 18, 0, 1));
        send_item(pack_date(-4717, 1, 1, 0, 0, 0));
        send_item(pack_date(0, 2, 28, 1, 2, 3));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                settle();
                if (ph == RANDOM_PHASE) begin
                    last_tab[ph]  = longint'($urandom_range(0, 2000000)) - 1000000;
                    last_tab[ph]  = last_tab[ph] * 10000 + $urandom_range(1, 12) * 100 +
                                    $urandom_range(1, 31);
                    first_tab[ph] = last_tab[ph] + $urandom_range(0, 20000);
                end
                write_switch(CFG_LAST_OLD, last_tab[ph]);
                write_switch(CFG_FIRST_NEW, first_tab[ph]);
                if (ph == SPARE_PHASE) begin
                    write_switch(CFG_SPARE_A, {$urandom, $urandom});
                    write_switch(CFG_SPARE_B, {$urandom, $urandom});
                end
                i_cfg_we <= 1'b0;
            end
            switch_date = last_tab[ph];
            if (ph == PRESSURE_PHASE) begin
                hold_flip <= ~hold_flip;
                gapless = 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == 60) begin
                    gapless = 1'b0;
                end
                send_item(random_date());
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("calendar_date_to_julian_day_top_tb OK");
        end else begin
            $display("calendar_date_to_julian_day_top_tb NOT OK");
        end
        $finish;
    end

endmodule
